>>> hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, codes and controller/datapath link types for the go-back-n
// sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W  = 3;   // sequence numbers modulo 8
  localparam int PAY_W  = 32;
  localparam int WIN    = 4;   // window slots
  localparam int IDX_W  = 2;   // slot index / result step
  localparam int CNT_W  = 3;   // outstanding count, 0..WIN
  localparam int FUNC_W = 2;
  localparam int TOP_W  = 2;
  localparam int KIND_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_SEND    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [TOP_W-1:0] TOP_NONE    = 2'd0;
  localparam logic [TOP_W-1:0] TOP_START   = 2'd1;
  localparam logic [TOP_W-1:0] TOP_STOP    = 2'd2;
  localparam logic [TOP_W-1:0] TOP_RESTART = 2'd3;

  // What an accepted item turns into
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESEND = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd3;

  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WIN);

  typedef struct packed {
    logic             start;  // item accepted this cycle
    logic             load;   // load output register with result of step
    logic [IDX_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] last_idx;  // index of the final result of the item
  } sts_t;

endpackage

>>> hdl/gbn_in_if.sv
// ----------------------------------------------------------------------------
// gbn_in_if
// Input item channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface gbn_in_if;
  logic                      valid;
  logic                      ready;
  logic [gbn_pkg::FUNC_W-1:0] func;
  logic [gbn_pkg::PAY_W-1:0]  payload_word;
  logic [gbn_pkg::SEQ_W-1:0]  ack_number;
  logic                      ack_check_ok;
  logic [gbn_pkg::SEQ_W-1:0]  timeout_seq;

  modport source (
    output valid, func, payload_word, ack_number, ack_check_ok, timeout_seq,
    input  ready
  );
  modport sink (
    input  valid, func, payload_word, ack_number, ack_check_ok, timeout_seq,
    output ready
  );
endinterface

>>> hdl/gbn_out_if.sv
// ----------------------------------------------------------------------------
// gbn_out_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface gbn_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic                      send_valid;
  logic [gbn_pkg::SEQ_W-1:0]  send_seq;
  logic [gbn_pkg::PAY_W-1:0]  send_payload;
  logic [gbn_pkg::TOP_W-1:0]  timer_op;
  logic [gbn_pkg::SEQ_W-1:0]  timer_seq;
  logic                      window_full;
  logic                      last;

  modport source (
    output valid, accepted, send_valid, send_seq, send_payload, timer_op,
           timer_seq, window_full, last,
    input  ready
  );
  modport sink (
    input  valid, accepted, send_valid, send_seq, send_payload, timer_op,
           timer_seq, window_full, last,
    output ready
  );
endinterface

>>> hdl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: accepts one item when idle, then steps through its results,
// one per output register load.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gbn_pkg::sts_t sts,
  output gbn_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_r, state_nxt;
  logic [gbn_pkg::IDX_W-1:0] step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  assign cmd.start = in_valid && in_ready;
  assign cmd.load  = load;
  assign cmd.step  = step_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          // leave after the final result of the item is loaded
          if (step_r == sts.last_idx) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp
// Window datapath: sequence state, payload store indexed by sequence number,
// item decode and the output register.
// ----------------------------------------------------------------------------
module gbn_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gbn_pkg::cmd_t              cmd,
  output gbn_pkg::sts_t              sts,
  input  logic [gbn_pkg::FUNC_W-1:0] in_func,
  input  logic [gbn_pkg::PAY_W-1:0]  in_payload_word,
  input  logic [gbn_pkg::SEQ_W-1:0]  in_ack_number,
  input  logic                       in_ack_check_ok,
  output logic                       out_accepted,
  output logic                       out_send_valid,
  output logic [gbn_pkg::SEQ_W-1:0]  out_send_seq,
  output logic [gbn_pkg::PAY_W-1:0]  out_send_payload,
  output logic [gbn_pkg::TOP_W-1:0]  out_timer_op,
  output logic [gbn_pkg::SEQ_W-1:0]  out_timer_seq,
  output logic                       out_window_full,
  output logic                       out_last
);

  // window state
  logic [gbn_pkg::SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [gbn_pkg::SEQ_W-1:0]  base_seq_r, base_seq_nxt;
  logic [gbn_pkg::CNT_W-1:0]  outs_r, outs_nxt;
  logic [gbn_pkg::PAY_W-1:0]  store_r [gbn_pkg::WIN];
  logic                       store_we;

  // current item
  logic [gbn_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [gbn_pkg::SEQ_W-1:0]  jbase_r, jbase_nxt;
  logic [gbn_pkg::IDX_W-1:0]  last_idx_r, last_idx_nxt;

  // output register
  logic                       acc_r, sv_r, full_r, last_r;
  logic [gbn_pkg::SEQ_W-1:0]  sseq_r, tseq_r;
  logic [gbn_pkg::PAY_W-1:0]  spay_r;
  logic [gbn_pkg::TOP_W-1:0]  top_r;

  logic [gbn_pkg::SEQ_W-1:0]  prev_seq;
  logic [gbn_pkg::SEQ_W-1:0]  ack_off;
  logic [gbn_pkg::SEQ_W-1:0]  step_seq;
  logic                       has_pay;

  assign prev_seq = base_seq_r - 1'b1;
  assign ack_off  = in_ack_number - base_seq_r;
  assign step_seq = jbase_r + {1'b0, cmd.step};
  assign has_pay  = (kind_r == gbn_pkg::KIND_SEND) || (kind_r == gbn_pkg::KIND_RESEND);

  assign sts.last_idx = last_idx_r;

  // decode the item and update the window when it is accepted
  always_comb begin
    next_seq_nxt = next_seq_r;
    base_seq_nxt = base_seq_r;
    outs_nxt     = outs_r;
    kind_nxt     = kind_r;
    jbase_nxt    = jbase_r;
    last_idx_nxt = last_idx_r;
    store_we     = 1'b0;
    if (cmd.start) begin
      kind_nxt     = gbn_pkg::KIND_EMPTY;
      jbase_nxt    = base_seq_r;
      last_idx_nxt = '0;
      case (in_func)
        gbn_pkg::FUNC_SEND: begin
          if (outs_r != gbn_pkg::WIN_CNT) begin
            kind_nxt     = gbn_pkg::KIND_SEND;
            jbase_nxt    = next_seq_r;
            store_we     = 1'b1;
            outs_nxt     = outs_r + 1'b1;
            next_seq_nxt = next_seq_r + 1'b1;
            if (outs_r == '0) begin
              base_seq_nxt = next_seq_r;
            end
          end
        end
        gbn_pkg::FUNC_ACK: begin
          if (in_ack_check_ok) begin
            if (in_ack_number == prev_seq) begin
              if (outs_r != '0) begin
                kind_nxt     = gbn_pkg::KIND_RESEND;
                last_idx_nxt = gbn_pkg::IDX_W'(outs_r - 1'b1);
              end
            end else if (ack_off < outs_r) begin
              // stop timers from base through the acked number, slide base
              kind_nxt     = gbn_pkg::KIND_STOP;
              last_idx_nxt = ack_off[gbn_pkg::IDX_W-1:0];
              outs_nxt     = outs_r - ack_off - 1'b1;
              base_seq_nxt = in_ack_number + 1'b1;
            end
          end
        end
        gbn_pkg::FUNC_TIMEOUT: begin
          if (outs_r != '0) begin
            kind_nxt     = gbn_pkg::KIND_RESEND;
            last_idx_nxt = gbn_pkg::IDX_W'(outs_r - 1'b1);
          end
        end
        default: begin
          kind_nxt = gbn_pkg::KIND_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r <= '0;
      base_seq_r <= '0;
      outs_r     <= '0;
      kind_r     <= gbn_pkg::KIND_EMPTY;
      last_idx_r <= '0;
    end else begin
      next_seq_r <= next_seq_nxt;
      base_seq_r <= base_seq_nxt;
      outs_r     <= outs_nxt;
      kind_r     <= kind_nxt;
      last_idx_r <= last_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jbase_r <= jbase_nxt;
    if (store_we) begin
      store_r[next_seq_r[gbn_pkg::IDX_W-1:0]] <= in_payload_word;
    end
  end

  // build one result per load; outstanding slots are unique modulo the window
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r  <= (kind_r == gbn_pkg::KIND_SEND);
      sv_r   <= has_pay;
      sseq_r <= has_pay ? step_seq : '0;
      spay_r <= has_pay ? store_r[step_seq[gbn_pkg::IDX_W-1:0]] : '0;
      tseq_r <= (kind_r == gbn_pkg::KIND_EMPTY) ? '0 : step_seq;
      full_r <= (outs_r == gbn_pkg::WIN_CNT);
      last_r <= (cmd.step == last_idx_r);
      case (kind_r)
        gbn_pkg::KIND_SEND:   top_r <= gbn_pkg::TOP_START;
        gbn_pkg::KIND_RESEND: top_r <= gbn_pkg::TOP_RESTART;
        gbn_pkg::KIND_STOP:   top_r <= gbn_pkg::TOP_STOP;
        default:              top_r <= gbn_pkg::TOP_NONE;
      endcase
    end
  end

  assign out_accepted     = acc_r;
  assign out_send_valid   = sv_r;
  assign out_send_seq     = sseq_r;
  assign out_send_payload = spay_r;
  assign out_timer_op     = top_r;
  assign out_timer_seq    = tseq_r;
  assign out_window_full  = full_r;
  assign out_last         = last_r;

endmodule

>>> hdl/go_back_n_sender_window_core.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// Go-back-n sender window of four packets with sequence numbers modulo 8.
// ----------------------------------------------------------------------------
// Each accepted item (send, ack or timer expiry) produces one to four result
// items, the final one marked by last. The block takes one item at a time:
// after the accept cycle the sequencer in gbn_ctrl loads one result per cycle
// into the output register while the result side does not stall. A new
// item is accepted as soon as the final result is loaded, even while that
// result still waits to be taken. Payloads live in a four-entry store indexed
// by the low bits of the sequence number.
module go_back_n_sender_window_core (
  input  logic clk,
  input  logic rst_n,
  gbn_in_if.sink    in_chan,
  gbn_out_if.source out_chan
);

  gbn_pkg::cmd_t cmd;
  gbn_pkg::sts_t sts;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_chan.func),
    .in_payload_word  (in_chan.payload_word),
    .in_ack_number    (in_chan.ack_number),
    .in_ack_check_ok  (in_chan.ack_check_ok),
    .out_accepted     (out_chan.accepted),
    .out_send_valid   (out_chan.send_valid),
    .out_send_seq     (out_chan.send_seq),
    .out_send_payload (out_chan.send_payload),
    .out_timer_op     (out_chan.timer_op),
    .out_timer_seq    (out_chan.timer_seq),
    .out_window_full  (out_chan.window_full),
    .out_last         (out_chan.last)
  );

endmodule

>>> tb/go_back_n_sender_window_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core_tb
// Self-checking bench for the go-back-n sender window. A directed table hits
// reset, the full window, bad and stale acks, wrap of the sequence numbers
// and timer expiry. Random traffic follows, mostly sends and in-window acks.
// Every result item is compared field by field with the table's expectation
// or a behavioral model of the window. Both handshakes idle at random in three
// patterns, and one long receiver hold-off backs up the input side.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core_tb;

  localparam logic [gbn_pkg::FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 400;

  typedef enum logic [1:0] {
    WANT_MODEL,
    WANT_EMPTY,
    WANT_SENT,
    WANT_REFUSED
  } want_kind_t;

  typedef struct packed {
    logic [gbn_pkg::FUNC_W-1:0] func;
    logic [gbn_pkg::PAY_W-1:0]  payload_word;
    logic [gbn_pkg::SEQ_W-1:0]  ack_number;
    logic                       ack_check_ok;
    logic [gbn_pkg::SEQ_W-1:0]  timeout_seq;
  } request_t;

  typedef struct packed {
    logic                       accepted;
    logic                       send_valid;
    logic [gbn_pkg::SEQ_W-1:0]  send_seq;
    logic [gbn_pkg::PAY_W-1:0]  send_payload;
    logic [gbn_pkg::TOP_W-1:0]  timer_op;
    logic [gbn_pkg::SEQ_W-1:0]  timer_seq;
    logic                       window_full;
    logic                       last;
  } result_t;

  typedef struct packed {
    request_t                   req;
    want_kind_t                 want;
    logic [gbn_pkg::SEQ_W-1:0]  want_seq;
    logic                       want_full;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gbn_in_if  in_if ();
  gbn_out_if out_if ();

  go_back_n_sender_window_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Window model state
  logic [gbn_pkg::SEQ_W-1:0] win_next = '0;
  logic [gbn_pkg::SEQ_W-1:0] win_base = '0;
  int                        win_count = 0;
  logic [gbn_pkg::PAY_W-1:0] win_store [gbn_pkg::WIN];

  result_t  expected_results [$];
  dir_row_t dir_rows [$];

  int error_count = 0;
  int cycle_count = 0;
  int snd_idle = 17;
  int rcv_idle = 75;
  int hold_req = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int n_items = 0;
  int n_taken = 0;
  int n_refused = 0;
  int n_stopped = 0;
  int n_resent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("go_back_n_sender_window_core_tb NOT OK");
      $finish;
    end
  end

  // Advance the window by one request; queue its results unless told not to.
  function automatic void window_step(request_t r, bit keep);
    result_t                   res [gbn_pkg::WIN];
    result_t                   blank;
    logic [gbn_pkg::SEQ_W-1:0] s;
    logic [gbn_pkg::SEQ_W-1:0] ack_off;
    int                        n;
    int                        d;
    int                        i;
    bit                        resend;
    blank  = '0;
    n      = 0;
    resend = 1'b0;
    case (r.func)
      gbn_pkg::FUNC_SEND: begin
        if (win_count >= gbn_pkg::WIN) begin
          n_refused++;
        end else begin
          if (win_count == 0) win_base = win_next;
          win_store[win_count] = r.payload_word;
          win_count++;
          res[0]              = blank;
          res[0].accepted     = 1'b1;
          res[0].send_valid   = 1'b1;
          res[0].send_seq     = win_next;
          res[0].send_payload = r.payload_word;
          res[0].timer_op     = gbn_pkg::TOP_START;
          res[0].timer_seq    = win_next;
          n        = 1;
          win_next = win_next + 1'b1;
          n_taken++;
        end
      end
      gbn_pkg::FUNC_ACK: begin
        if (r.ack_check_ok) begin
          if (r.ack_number == win_base - 1'b1) begin
            resend = 1'b1;
          end else begin
            ack_off = r.ack_number - win_base;
            d       = ack_off;
            // Cumulative ack: stop every timer up to and including ack_number
            if (d < win_count) begin
              for (i = 0; i <= d; i++) begin
                res[n]           = blank;
                res[n].timer_op  = gbn_pkg::TOP_STOP;
                res[n].timer_seq = win_base + gbn_pkg::SEQ_W'(i);
                n++;
              end
              for (i = 0; i + d + 1 < win_count; i++) win_store[i] = win_store[i + d + 1];
              win_count = win_count - (d + 1);
              win_base  = win_base + gbn_pkg::SEQ_W'(d + 1);
              n_stopped += d + 1;
            end
          end
        end
      end
      gbn_pkg::FUNC_TIMEOUT: resend = 1'b1;
      default: ;
    endcase
    if (resend) begin
      for (i = 0; i < win_count; i++) begin
        s                   = win_base + gbn_pkg::SEQ_W'(i);
        res[n]              = blank;
        res[n].send_valid   = 1'b1;
        res[n].send_seq     = s;
        res[n].send_payload = win_store[i];
        res[n].timer_op     = gbn_pkg::TOP_RESTART;
        res[n].timer_seq    = s;
        n++;
      end
      n_resent += win_count;
    end
    if (n == 0) begin
      res[0] = blank;
      n      = 1;
    end
    for (i = 0; i < n; i++) res[i].window_full = (win_count >= gbn_pkg::WIN);
    res[n-1].last = 1'b1;
    if (keep) begin
      for (i = 0; i < n; i++) expected_results.push_back(res[i]);
    end
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       roll;
    r.func         = gbn_pkg::FUNC_SEND;
    r.payload_word = $urandom;
    r.ack_number   = gbn_pkg::SEQ_W'($urandom);
    r.ack_check_ok = 1'b1;
    r.timeout_seq  = gbn_pkg::SEQ_W'($urandom);
    if ($urandom_range(9) == 0) begin
      r.payload_word = $urandom_range(1) ? {gbn_pkg::PAY_W{1'b1}} : {gbn_pkg::PAY_W{1'b0}};
    end
    roll = $urandom_range(99);
    if (roll < 45) begin
      r.func = gbn_pkg::FUNC_SEND;
    end else if (roll < 70) begin
      r.func = gbn_pkg::FUNC_ACK;
      if (win_count > 0) begin
        r.ack_number = win_base + gbn_pkg::SEQ_W'($urandom_range(win_count - 1));
      end
    end else if (roll < 78) begin
      r.func       = gbn_pkg::FUNC_ACK;
      r.ack_number = win_base - 1'b1;
    end else if (roll < 86) begin
      r.func = gbn_pkg::FUNC_TIMEOUT;
    end else begin
      // Noise: any func, any check bit
      r.func         = gbn_pkg::FUNC_W'($urandom_range(3));
      r.ack_check_ok = 1'($urandom_range(1));
    end
    return r;
  endfunction

  function automatic void add_row(logic [gbn_pkg::FUNC_W-1:0] f,
                                  logic [gbn_pkg::PAY_W-1:0] p,
                                  logic [gbn_pkg::SEQ_W-1:0] a, logic ok,
                                  logic [gbn_pkg::SEQ_W-1:0] t,
                                  want_kind_t k, logic [gbn_pkg::SEQ_W-1:0] seq,
                                  logic full);
    dir_row_t row;
    row.req.func         = f;
    row.req.payload_word = p;
    row.req.ack_number   = a;
    row.req.ack_check_ok = ok;
    row.req.timeout_seq  = t;
    row.want             = k;
    row.want_seq         = seq;
    row.want_full        = full;
    dir_rows.push_back(row);
  endfunction

  // Offer one item, hold it until taken, then maybe idle.
  task automatic issue(request_t r, bit typed, result_t want);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.func         <= r.func;
    in_if.payload_word <= r.payload_word;
    in_if.ack_number   <= r.ack_number;
    in_if.ack_check_ok <= r.ack_check_ok;
    in_if.timeout_seq  <= r.timeout_seq;
    do @(posedge clk); while (!in_if.ready);
    window_step(r, !typed);
    if (typed) expected_results.push_back(want);
    n_items++;
    gap = 0;
    while ($urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item arrived with none expected");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_if.accepted));
        check_field("send_valid", 32'(want.send_valid), 32'(out_if.send_valid));
        check_field("send_seq", 32'(want.send_seq), 32'(out_if.send_seq));
        check_field("send_payload", want.send_payload, out_if.send_payload);
        check_field("timer_op", 32'(want.timer_op), 32'(out_if.timer_op));
        check_field("timer_seq", 32'(want.timer_seq), 32'(out_if.timer_seq));
        check_field("window_full", 32'(want.window_full), 32'(out_if.window_full));
        check_field("last", 32'(want.last), 32'(out_if.last));
      end
    end
  end

  // Receiver: random ready, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req != 0 && !hold_done) begin
      hold_done    = 1'b1;
      hold_left    = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    request_t r;
    result_t  want;
    int       counted;
    int       phase;
    int       k;

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.func         <= '0;
    in_if.payload_word <= '0;
    in_if.ack_number   <= '0;
    in_if.ack_check_ok <= 1'b0;
    in_if.timeout_seq  <= '0;

    // Empty window: expiry, stale ack, bad check, unknown func
    add_row(gbn_pkg::FUNC_TIMEOUT, 32'h0, 3'd7, 1'b0, 3'd7, WANT_EMPTY, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd7, 1'b1, 3'd0, WANT_EMPTY, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd3, 1'b0, 3'd0, WANT_EMPTY, 3'd0, 1'b0);
    add_row(FUNC_IGNORED, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7, WANT_EMPTY, 3'd0, 1'b0);
    // Fill the window, then one refused send
    add_row(gbn_pkg::FUNC_SEND, 32'h0000_0000, 3'd0, 1'b0, 3'd0, WANT_SENT, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7, WANT_SENT, 3'd1, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'hA5A5_A5A5, 3'd2, 1'b0, 3'd5, WANT_SENT, 3'd2, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'h5A5A_5A5A, 3'd5, 1'b1, 3'd2, WANT_SENT, 3'd3, 1'b1);
    add_row(gbn_pkg::FUNC_SEND, 32'h1234_5678, 3'd0, 1'b0, 3'd0, WANT_REFUSED, 3'd0, 1'b1);
    // Full window: expiry and duplicate ack resend all four
    add_row(gbn_pkg::FUNC_TIMEOUT, 32'h0, 3'd0, 1'b0, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd7, 1'b1, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd6, 1'b1, 3'd0, WANT_EMPTY, 3'd0, 1'b1);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd0, 1'b0, 3'd0, WANT_EMPTY, 3'd0, 1'b1);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd1, 1'b1, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'hDEAD_BEEF, 3'd0, 1'b0, 3'd0, WANT_SENT, 3'd4, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'h0000_0000, 3'd0, 1'b0, 3'd0, WANT_SENT, 3'd5, 1'b1);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd5, 1'b1, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    // Wrap the sequence numbers through 7 -> 0
    add_row(gbn_pkg::FUNC_SEND, 32'h0000_0001, 3'd0, 1'b0, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'h8000_0000, 3'd0, 1'b0, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'h7FFF_FFFF, 3'd0, 1'b0, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_SEND, 32'hFFFF_FFFE, 3'd0, 1'b0, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd0, 1'b1, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_TIMEOUT, 32'h0, 3'd0, 1'b0, 3'd5, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd1, 1'b1, 3'd0, WANT_MODEL, 3'd0, 1'b0);
    add_row(gbn_pkg::FUNC_ACK, 32'h0, 3'd1, 1'b1, 3'd0, WANT_EMPTY, 3'd0, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < dir_rows.size(); k++) begin
      want = '0;
      if (dir_rows[k].want == WANT_SENT) begin
        want.accepted     = 1'b1;
        want.send_valid   = 1'b1;
        want.send_seq     = dir_rows[k].want_seq;
        want.send_payload = dir_rows[k].req.payload_word;
        want.timer_op     = gbn_pkg::TOP_START;
        want.timer_seq    = dir_rows[k].want_seq;
      end
      want.window_full = dir_rows[k].want_full;
      want.last        = 1'b1;
      issue(dir_rows[k].req, dir_rows[k].want != WANT_MODEL, want);
    end

    counted = 0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle = 17;
          rcv_idle = 75;
        end
        1: begin
          snd_idle = 75;
          rcv_idle = 17;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          hold_req = 1;
        end
      endcase
      while (counted < (RANDOM_ITEMS * (phase + 1)) / 3) begin
        r = random_request();
        want = '0;
        issue(r, 1'b0, want);
        if (!(r.func == FUNC_IGNORED || (r.func == gbn_pkg::FUNC_ACK && !r.ack_check_ok))) begin
          counted++;
        end
      end
    end
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d sends taken, %0d refused on a full window,",
             n_items, n_taken, n_refused);
    $display("%0d timers stopped by acks, %0d packets retransmitted, under three idle patterns.",
             n_stopped, n_resent);
    if (error_count == 0) begin
      $display("go_back_n_sender_window_core_tb OK");
    end else begin
      $display("go_back_n_sender_window_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/gbn_pkg.sv
hdl/gbn_in_if.sv
hdl/gbn_out_if.sv
hdl/gbn_ctrl.sv
hdl/gbn_dp.sv
hdl/go_back_n_sender_window_core.sv
tb/go_back_n_sender_window_core_tb.sv
